// ===== rtl/cmhb_pkg.sv =====
// Shared types, codes, tables and helpers for the CABAC macroblock-header binarizer.
`timescale 1ns / 1ps

package cmhb_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Element codes carried on the input tuser
    localparam logic [2:0] CMD_MB_TYPE      = 3'd0;
    localparam logic [2:0] CMD_MB_SKIP      = 3'd1;
    localparam logic [2:0] CMD_CHROMA_MODE  = 3'd2;
    localparam logic [2:0] CMD_QP_DELTA     = 3'd3;
    localparam logic [2:0] CMD_END_OF_SLICE = 3'd4;

    // Slice kinds
    localparam logic [1:0] SLICE_I  = 2'd0;
    localparam logic [1:0] SLICE_SI = 2'd1;
    localparam logic [1:0] SLICE_P  = 2'd2;
    localparam logic [1:0] SLICE_B  = 2'd3;

    // Neighbour macroblock kinds
    localparam logic [2:0] KIND_INTER    = 3'd1;
    localparam logic [2:0] KIND_SI       = 3'd2;
    localparam logic [2:0] KIND_I_NXN    = 3'd3;
    localparam logic [2:0] KIND_I_PCM    = 3'd4;
    localparam logic [2:0] KIND_B_SKIP   = 3'd5;
    localparam logic [2:0] KIND_B_DIRECT = 3'd6;

    // Context indexes
    localparam logic [8:0] CTX_TERM      = 9'd276;
    localparam logic [8:0] CTX_SI_PRE    = 9'd0;
    localparam logic [8:0] CTX_I_BASE    = 9'd3;
    localparam logic [8:0] CTX_P_SKIP    = 9'd11;
    localparam logic [8:0] CTX_P_PRE     = 9'd14;
    localparam logic [8:0] CTX_P_SUF     = 9'd17;
    localparam logic [8:0] CTX_B_SKIP    = 9'd24;
    localparam logic [8:0] CTX_B_PRE     = 9'd27;
    localparam logic [8:0] CTX_B_SUF     = 9'd32;
    localparam logic [8:0] CTX_QP_FIRST  = 9'd60;
    localparam logic [8:0] CTX_QP_SECOND = 9'd62;
    localparam logic [8:0] CTX_QP_REST   = 9'd63;
    localparam logic [8:0] CTX_CHROMA    = 9'd64;
    localparam logic [8:0] CTX_CHROMA_R  = 9'd67;

    // B prefix that escapes to an intra suffix
    localparam logic [6:0] B_INTRA_PREFIX = 7'b0111101;

    // Context selection scheme for one run of bins
    typedef enum logic [2:0] {
        SCH_I,
        SCH_SUF,
        SCH_PPRE,
        SCH_BPRE,
        SCH_FLAG,
        SCH_CHROMA,
        SCH_QP
    } sch_t;

    // One run of bins: a bit string MSB first, or a unary run for SCH_QP
    typedef struct packed {
        sch_t       sch;
        logic [6:0] val;
        logic [5:0] len;
        logic [8:0] c0;
    } seg_t;

    // Work for one element as handed from front to back
    typedef struct packed {
        logic err;
        logic two;
        seg_t s0;
        seg_t s1;
    } job_t;

    function automatic seg_t mk_seg(sch_t s, logic [6:0] v, logic [5:0] l, logic [8:0] c);
        seg_t r;
        r.sch = s;
        r.val = v;
        r.len = l;
        r.c0  = c;
        return r;
    endfunction

    function automatic logic [6:0] itype_val(logic [4:0] idx);
        logic [6:0] r;
        case (idx)
            5'd0:  r = 7'h00;
            5'd1:  r = 7'h20;
            5'd2:  r = 7'h21;
            5'd3:  r = 7'h22;
            5'd4:  r = 7'h23;
            5'd5:  r = 7'h48;
            5'd6:  r = 7'h49;
            5'd7:  r = 7'h4A;
            5'd8:  r = 7'h4B;
            5'd9:  r = 7'h4C;
            5'd10: r = 7'h4D;
            5'd11: r = 7'h4E;
            5'd12: r = 7'h4F;
            5'd13: r = 7'h28;
            5'd14: r = 7'h29;
            5'd15: r = 7'h2A;
            5'd16: r = 7'h2B;
            5'd17: r = 7'h58;
            5'd18: r = 7'h59;
            5'd19: r = 7'h5A;
            5'd20: r = 7'h5B;
            5'd21: r = 7'h5C;
            5'd22: r = 7'h5D;
            5'd23: r = 7'h5E;
            5'd24: r = 7'h5F;
            5'd25: r = 7'h03;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] itype_len(logic [4:0] idx);
        logic [5:0] r;
        case (idx)
            5'd0:                                r = 6'd1;
            5'd1, 5'd2, 5'd3, 5'd4:              r = 6'd6;
            5'd13, 5'd14, 5'd15, 5'd16:          r = 6'd6;
            5'd25:                               r = 6'd2;
            default:                             r = 6'd7;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] ptype_val(logic [1:0] idx);
        logic [6:0] r;
        case (idx)
            2'd0:    r = 7'h0;
            2'd1:    r = 7'h3;
            2'd2:    r = 7'h2;
            default: r = 7'h1;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] btype_val(logic [4:0] idx);
        logic [6:0] r;
        case (idx)
            5'd0:  r = 7'h00;
            5'd1:  r = 7'h04;
            5'd2:  r = 7'h05;
            5'd3:  r = 7'h30;
            5'd4:  r = 7'h31;
            5'd5:  r = 7'h32;
            5'd6:  r = 7'h33;
            5'd7:  r = 7'h34;
            5'd8:  r = 7'h35;
            5'd9:  r = 7'h36;
            5'd10: r = 7'h37;
            5'd11: r = 7'h3E;
            5'd12: r = 7'h70;
            5'd13: r = 7'h71;
            5'd14: r = 7'h72;
            5'd15: r = 7'h73;
            5'd16: r = 7'h74;
            5'd17: r = 7'h75;
            5'd18: r = 7'h76;
            5'd19: r = 7'h77;
            5'd20: r = 7'h78;
            5'd21: r = 7'h79;
            5'd22: r = 7'h3F;
            default: r = 7'h00;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] btype_len(logic [4:0] idx);
        logic [5:0] r;
        if (idx == 5'd0)
            r = 6'd1;
        else if (idx <= 5'd2)
            r = 6'd3;
        else if (idx <= 5'd11 || idx == 5'd22)
            r = 6'd6;
        else
            r = 6'd7;
        return r;
    endfunction

endpackage

// ===== rtl/cmhb_front.sv =====
// Front end: slice register, element checks and bin-string/context-base selection.
`timescale 1ns / 1ps

module cmhb_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic [2:0]        command,
    input  logic [5:0]        element_value,
    input  logic signed [5:0] qp_delta,
    input  logic              left_present,
    input  logic              left_skipped,
    input  logic [2:0]        left_kind,
    input  logic              left_chroma_nonzero,
    input  logic              above_present,
    input  logic              above_skipped,
    input  logic [2:0]        above_kind,
    input  logic              above_chroma_nonzero,
    output cmhb_pkg::job_t    job
);

    logic [1:0] slice_kind_reg;
    logic [1:0] slice_kind_next;

    logic [8:0] inc_si;
    logic [8:0] inc_i;
    logic [8:0] inc_b;
    logic [8:0] inc_skip;
    logic [8:0] inc_chroma;
    logic [5:0] raw;
    logic [5:0] idx_si;
    logic [5:0] idx_p;
    logic [5:0] idx_b;
    logic signed [7:0] qx;
    logic signed [7:0] qn;
    logic [6:0] chroma_val;
    logic [5:0] chroma_len;

    function automatic logic type_cond(logic present, logic [2:0] kind, logic [1:0] which);
        logic r;
        r = present;
        if (which == 2'd0 && kind == cmhb_pkg::KIND_SI)
            r = 1'b0;
        if (which == 2'd1 && kind == cmhb_pkg::KIND_I_NXN)
            r = 1'b0;
        if (which == 2'd2 && (kind == cmhb_pkg::KIND_B_SKIP || kind == cmhb_pkg::KIND_B_DIRECT))
            r = 1'b0;
        return r;
    endfunction

    function automatic logic chroma_cond(logic present, logic [2:0] kind, logic nz);
        logic inter;
        inter = (kind == cmhb_pkg::KIND_INTER) || (kind == cmhb_pkg::KIND_I_PCM)
             || (kind == cmhb_pkg::KIND_B_SKIP) || (kind == cmhb_pkg::KIND_B_DIRECT);
        return present && !inter && nz;
    endfunction

    always_comb
    begin
        slice_kind_next = cfg_we ? cfg_wdata : slice_kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slice_kind_reg <= cmhb_pkg::SLICE_I;
        else
            slice_kind_reg <= slice_kind_next;
    end

    // Neighbour-dependent context bases
    always_comb
    begin
        inc_si = cmhb_pkg::CTX_SI_PRE
               + 9'(type_cond(left_present, left_kind, 2'd0))
               + 9'(type_cond(above_present, above_kind, 2'd0));
        inc_i  = cmhb_pkg::CTX_I_BASE
               + 9'(type_cond(left_present, left_kind, 2'd1))
               + 9'(type_cond(above_present, above_kind, 2'd1));
        inc_b  = cmhb_pkg::CTX_B_PRE
               + 9'(type_cond(left_present, left_kind, 2'd2))
               + 9'(type_cond(above_present, above_kind, 2'd2));
        inc_skip = ((slice_kind_reg == cmhb_pkg::SLICE_P) ? cmhb_pkg::CTX_P_SKIP
                                                          : cmhb_pkg::CTX_B_SKIP)
                 + 9'(left_present && !left_skipped)
                 + 9'(above_present && !above_skipped);
        inc_chroma = cmhb_pkg::CTX_CHROMA
                   + 9'(chroma_cond(left_present, left_kind, left_chroma_nonzero))
                   + 9'(chroma_cond(above_present, above_kind, above_chroma_nonzero));
    end

    always_comb
    begin
        raw    = element_value;
        idx_si = raw - 6'd1;
        idx_p  = raw - 6'd5;
        idx_b  = raw - 6'd23;
        // bin count of the QP delta: unary ones plus the closing zero
        qx = 8'(qp_delta);
        qn = (qx <= 8'sd0) ? (8'sd1 - (qx <<< 1)) : (qx <<< 1);
        case (raw[1:0])
            2'd0:    chroma_val = 7'b0000000;
            2'd1:    chroma_val = 7'b0000010;
            default: chroma_val = {4'b0000, 2'b11, raw[0]};
        endcase
        chroma_len = (raw[1:0] == 2'd3) ? 6'd3 : (6'(raw[1:0]) + 6'd1);

        job     = '0;
        job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_FLAG, 7'd0, 6'd1, 9'd0);
        job.s1  = job.s0;
        case (command)
            cmhb_pkg::CMD_MB_TYPE:
            begin
                case (slice_kind_reg)
                    cmhb_pkg::SLICE_I:
                    begin
                        job.err = (raw > 6'd25);
                        job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_I,
                                      cmhb_pkg::itype_val(raw[4:0]),
                                      cmhb_pkg::itype_len(raw[4:0]), inc_i);
                    end
                    cmhb_pkg::SLICE_SI:
                    begin
                        job.err = (raw > 6'd26);
                        job.two = (raw != 6'd0);
                        job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_FLAG,
                                      7'(raw != 6'd0), 6'd1, inc_si);
                        job.s1  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_I,
                                      cmhb_pkg::itype_val(idx_si[4:0]),
                                      cmhb_pkg::itype_len(idx_si[4:0]), inc_i);
                    end
                    cmhb_pkg::SLICE_P:
                    begin
                        job.err = (raw > 6'd30) || (raw == 6'd4);
                        if (raw < 6'd4)
                        begin
                            job.s0 = cmhb_pkg::mk_seg(cmhb_pkg::SCH_PPRE,
                                         cmhb_pkg::ptype_val(raw[1:0]), 6'd3,
                                         cmhb_pkg::CTX_P_PRE);
                        end
                        else
                        begin
                            job.two = 1'b1;
                            job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_FLAG, 7'd1, 6'd1,
                                          cmhb_pkg::CTX_P_PRE);
                            job.s1  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_SUF,
                                          cmhb_pkg::itype_val(idx_p[4:0]),
                                          cmhb_pkg::itype_len(idx_p[4:0]),
                                          cmhb_pkg::CTX_P_SUF);
                        end
                    end
                    default:
                    begin
                        job.err = (raw > 6'd48);
                        if (raw <= 6'd22)
                        begin
                            job.s0 = cmhb_pkg::mk_seg(cmhb_pkg::SCH_BPRE,
                                         cmhb_pkg::btype_val(raw[4:0]),
                                         cmhb_pkg::btype_len(raw[4:0]), inc_b);
                        end
                        else
                        begin
                            job.two = 1'b1;
                            job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_BPRE,
                                          cmhb_pkg::B_INTRA_PREFIX, 6'd6, inc_b);
                            job.s1  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_SUF,
                                          cmhb_pkg::itype_val(idx_b[4:0]),
                                          cmhb_pkg::itype_len(idx_b[4:0]),
                                          cmhb_pkg::CTX_B_SUF);
                        end
                    end
                endcase
            end
            cmhb_pkg::CMD_MB_SKIP:
            begin
                job.err = (slice_kind_reg == cmhb_pkg::SLICE_I)
                       || (slice_kind_reg == cmhb_pkg::SLICE_SI);
                job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_FLAG, 7'(raw[0]), 6'd1, inc_skip);
            end
            cmhb_pkg::CMD_CHROMA_MODE:
            begin
                job.err = (raw > 6'd3);
                job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_CHROMA, chroma_val, chroma_len,
                                           inc_chroma);
            end
            cmhb_pkg::CMD_QP_DELTA:
            begin
                job.err = (qp_delta < -6'sd26) || (qp_delta > 6'sd25);
                job.s0  = cmhb_pkg::mk_seg(cmhb_pkg::SCH_QP, 7'd0, qn[5:0],
                                           cmhb_pkg::CTX_QP_FIRST);
            end
            cmhb_pkg::CMD_END_OF_SLICE:
            begin
                job.s0 = cmhb_pkg::mk_seg(cmhb_pkg::SCH_FLAG, 7'(raw[0]), 6'd1,
                                          cmhb_pkg::CTX_TERM);
            end
            default:
            begin
                job.err = 1'b1;
            end
        endcase
        if (job.err)
            job.two = 1'b0;
    end

endmodule

// ===== rtl/cmhb_queue.sv =====
// Short first-word-fall-through queue of element jobs between front and back.
`timescale 1ns / 1ps

module cmhb_queue
#(
    parameter int DEPTH = cmhb_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cmhb_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output cmhb_pkg::job_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmhb_pkg::job_t store_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/cmhb_back.sv =====
// Back end: walks queued jobs one bin per cycle unless stalled; registers beats.
`timescale 1ns / 1ps

module cmhb_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  cmhb_pkg::job_t head_data,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_bin,
    output logic [8:0]     out_ctx,
    output logic           out_term,
    output logic           out_err,
    output logic           out_last
);

    logic       seg_sel_reg;
    logic       seg_sel_next;
    logic [5:0] k_reg;
    logic [5:0] k_next;
    logic       valid_reg;
    logic       valid_next;
    logic       bin_reg;
    logic [8:0] ctx_reg;
    logic       err_reg;
    logic       last_reg;

    cmhb_pkg::seg_t cur;
    logic       advance;
    logic       emit;
    logic [7:0] vpad;
    logic [2:0] pos;
    logic [2:0] pos3;
    logic [2:0] pos1;
    logic       b3;
    logic       b1;
    logic       seg_end;
    logic       bin_c;
    logic [8:0] ctx_c;
    logic       last_c;

    assign advance = !valid_reg || out_ready;
    assign emit    = advance && head_valid;

    always_comb
    begin
        cur     = seg_sel_reg ? head_data.s1 : head_data.s0;
        vpad    = {1'b0, cur.val};
        pos     = cur.len[2:0] - 3'd1 - k_reg[2:0];
        pos3    = cur.len[2:0] - 3'd4;
        pos1    = cur.len[2:0] - 3'd2;
        b3      = vpad[pos3];
        b1      = vpad[pos1];
        seg_end = (k_reg == cur.len - 6'd1);
        bin_c   = vpad[pos];
        ctx_c   = cur.c0;
        unique case (cur.sch)
            cmhb_pkg::SCH_I:
            begin
                case (k_reg)
                    6'd0:    ctx_c = cur.c0;
                    6'd1:    ctx_c = cmhb_pkg::CTX_TERM;
                    6'd2:    ctx_c = 9'd6;
                    6'd3:    ctx_c = 9'd7;
                    6'd4:    ctx_c = b3 ? 9'd8 : 9'd9;
                    6'd5:    ctx_c = b3 ? 9'd9 : 9'd10;
                    default: ctx_c = 9'd10;
                endcase
            end
            cmhb_pkg::SCH_SUF:
            begin
                case (k_reg)
                    6'd0:    ctx_c = cur.c0;
                    6'd1:    ctx_c = cmhb_pkg::CTX_TERM;
                    6'd2:    ctx_c = cur.c0 + 9'd1;
                    6'd3:    ctx_c = cur.c0 + 9'd2;
                    6'd4:    ctx_c = cur.c0 + (b3 ? 9'd2 : 9'd3);
                    default: ctx_c = cur.c0 + 9'd3;
                endcase
            end
            cmhb_pkg::SCH_PPRE:
            begin
                case (k_reg)
                    6'd0:    ctx_c = 9'd14;
                    6'd1:    ctx_c = 9'd15;
                    default: ctx_c = b1 ? 9'd17 : 9'd16;
                endcase
            end
            cmhb_pkg::SCH_BPRE:
            begin
                case (k_reg)
                    6'd0:    ctx_c = cur.c0;
                    6'd1:    ctx_c = 9'd30;
                    6'd2:    ctx_c = b1 ? 9'd31 : 9'd32;
                    default: ctx_c = 9'd32;
                endcase
            end
            cmhb_pkg::SCH_FLAG:
            begin
                ctx_c = cur.c0;
            end
            cmhb_pkg::SCH_CHROMA:
            begin
                ctx_c = (k_reg == 6'd0) ? cur.c0 : cmhb_pkg::CTX_CHROMA_R;
            end
            cmhb_pkg::SCH_QP:
            begin
                // ones then a closing zero
                bin_c = !seg_end;
                case (k_reg)
                    6'd0:    ctx_c = cmhb_pkg::CTX_QP_FIRST;
                    6'd1:    ctx_c = cmhb_pkg::CTX_QP_SECOND;
                    default: ctx_c = cmhb_pkg::CTX_QP_REST;
                endcase
            end
            default:
            begin
                ctx_c = cur.c0;
            end
        endcase
        last_c = head_data.err || (seg_end && (seg_sel_reg || !head_data.two));
        if (head_data.err)
        begin
            bin_c = 1'b0;
            ctx_c = '0;
        end
    end

    always_comb
    begin
        pop          = emit && last_c;
        seg_sel_next = seg_sel_reg;
        k_next       = k_reg;
        if (emit)
        begin
            if (last_c)
            begin
                seg_sel_next = 1'b0;
                k_next       = '0;
            end
            else if (seg_end)
            begin
                seg_sel_next = 1'b1;
                k_next       = '0;
            end
            else
            begin
                k_next = k_reg + 6'd1;
            end
        end
        if (emit)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_sel_reg <= 1'b0;
            k_reg       <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            seg_sel_reg <= seg_sel_next;
            k_reg       <= k_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            bin_reg  <= bin_c;
            ctx_reg  <= ctx_c;
            err_reg  <= head_data.err;
            last_reg <= last_c;
        end
    end

    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_ctx   = ctx_reg;
    assign out_term  = (ctx_reg == cmhb_pkg::CTX_TERM);
    assign out_err   = err_reg;
    assign out_last  = last_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg |-> last_reg && !bin_reg && ctx_reg == '0)
        else $error("error beat not a lone last beat");

    a_second_seg_exists: assert property (@(posedge clk) disable iff (!rst_n)
        seg_sel_reg |-> head_valid && head_data.two && !head_data.err)
        else $error("second run selected without one queued");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(ctx_reg) && $stable(last_reg))
        else $error("result beat changed while stalled");

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !head_data.err |-> k_reg < cur.len)
        else $error("bin counter past end of run");

endmodule

// ===== rtl/cabac_mb_header_binarizer_core.sv =====
// Top level of the CABAC macroblock-header binarizer and context selector.
`timescale 1ns / 1ps

// Binarizes one macroblock-header syntax element per input transfer and
// emits one result transfer per bin, MSB first, with its ctxIdx; context 276
// marks terminate coding and tlast marks the final bin. An element that
// cannot be coded in the current slice gives one error transfer. The front
// end classifies an element in the cycle it is accepted and pushes it into a
// short queue (QUEUE_DEPTH entries); the back end walks the queue head and
// delivers one bin per cycle through an output register unless m_axis_tready
// stalls it. An element gives 1 bin for flags and errors, up to 13 for mb_type,
// 1 to 53 for the QP delta; bins pass the queue, then the output register.
// Unstalled, single-bin elements stream at one per cycle. The user must write
// slice_kind through cfg_we/cfg_wdata while the block is idle (not enforced).
module cabac_mb_header_binarizer_core
#(
    parameter int QUEUE_DEPTH = cmhb_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,      // slice_kind
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] element_value, [11:6] qp_delta, [12] left_present, [13] left_skipped,
    // [16:14] left_kind, [17] left_chroma_nonzero, [18] above_present,
    // [19] above_skipped, [22:20] above_kind, [23] above_chroma_nonzero
    input  logic [23:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,   // [2:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] bin, [9:1] context_index, [15:10] zero
    output logic [1:0]  m_axis_tuser,   // [0] terminate_mode, [1] error
    output logic        m_axis_tlast
);

    cmhb_pkg::job_t front_job;
    cmhb_pkg::job_t head_job;
    logic           q_full;
    logic           q_head_valid;
    logic           q_pop;
    logic           push;
    logic           out_bin;
    logic [8:0]     out_ctx;
    logic           out_term;
    logic           out_err;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    cmhb_front u_front
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .command              (s_axis_tuser),
        .element_value        (s_axis_tdata[5:0]),
        .qp_delta             (s_axis_tdata[11:6]),
        .left_present         (s_axis_tdata[12]),
        .left_skipped         (s_axis_tdata[13]),
        .left_kind            (s_axis_tdata[16:14]),
        .left_chroma_nonzero  (s_axis_tdata[17]),
        .above_present        (s_axis_tdata[18]),
        .above_skipped        (s_axis_tdata[19]),
        .above_kind           (s_axis_tdata[22:20]),
        .above_chroma_nonzero (s_axis_tdata[23]),
        .job                  (front_job)
    );

    cmhb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (front_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (head_job)
    );

    cmhb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (head_job),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_bin    (out_bin),
        .out_ctx    (out_ctx),
        .out_term   (out_term),
        .out_err    (out_err),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b000000, out_ctx, out_bin};
    assign m_axis_tuser = {out_err, out_term};

endmodule

// ===== sim/tb_cabac_mb_header_binarizer_core.sv =====
// Self-checking testbench for the CABAC macroblock-header binarizer core.
`timescale 1ns / 1ps

module tb_cabac_mb_header_binarizer_core;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 8;

    // command codes the block does not know
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic              [2:0] command;
        logic              [5:0] value;
        logic              [5:0] qp_delta;
        logic                    left_present;
        logic                    left_skipped;
        logic              [2:0] left_kind;
        logic                    left_chroma;
        logic                    above_present;
        logic                    above_skipped;
        logic              [2:0] above_kind;
        logic                    above_chroma;
    } element_t;

    typedef struct packed {
        logic       bin_val;
        logic [8:0] ctx;
        logic       term;
        logic       err;
        logic       last;
    } bin_t;

    typedef struct packed {
        logic [6:0] code;
        logic [5:0] len;
    } bin_string_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    element_t    pending_q[$];
    bin_t        expected_bins[$];
    bin_t        element_bins[$];
    element_t    offered = '0;
    logic [1:0]  slice_now = cmhb_pkg::SLICE_I;
    int          idle_pct = 37;
    int          accepted_items = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    int          cycles = 0;
    int          mismatches = 0;

    cabac_mb_header_binarizer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // I mb_type strings built from their structure: 1..24 are I_16x16 with
    // prefix 10, luma cbp bit, chroma cbp (0 / 10 / 11), two pred mode bits
    function automatic bin_string_t intra_string(int unsigned i);
        bin_string_t s;
        int unsigned j;
        j = i - 1;
        if (i == 0)
        begin
            s.code = 7'b0;
            s.len  = 6'd1;
        end
        else if (i == 25)
        begin
            s.code = 7'b11;
            s.len  = 6'd2;
        end
        else if ((j % 12) / 4 == 0)
        begin
            s.code = {1'b0, 2'b10, 1'(j / 12), 1'b0, 2'(j % 4)};
            s.len  = 6'd6;
        end
        else
        begin
            s.code = {2'b10, 1'(j / 12), 1'b1, 1'((j % 12) / 4 - 1), 2'(j % 4)};
            s.len  = 6'd7;
        end
        return s;
    endfunction

    function automatic bin_string_t b_string(int unsigned i);
        bin_string_t s;
        if (i == 0)
        begin
            s.code = 7'b0;
            s.len  = 6'd1;
        end
        else if (i <= 2)
        begin
            s.code = 7'(i + 3);
            s.len  = 6'd3;
        end
        else if (i <= 10)
        begin
            s.code = 7'(i - 3 + 'h30);
            s.len  = 6'd6;
        end
        else if (i == 11)
        begin
            s.code = 7'h3E;
            s.len  = 6'd6;
        end
        else if (i <= 21)
        begin
            s.code = 7'(i - 12 + 'h70);
            s.len  = 6'd7;
        end
        else
        begin
            s.code = 7'h3F;
            s.len  = 6'd6;
        end
        return s;
    endfunction

    function automatic logic bit_of(bin_string_t s, int k);
        logic [6:0] shifted;
        shifted = s.code >> (s.len - 1 - k);
        return shifted[0];
    endfunction

    function automatic logic [8:0] pick_ctx(cmhb_pkg::sch_t sch, int k, bin_string_t s,
                                            logic [8:0] c0);
        logic [8:0] r;
        case (sch)
            cmhb_pkg::SCH_I:
            begin
                if (k == 0)
                    r = c0;
                else if (k == 1)
                    r = cmhb_pkg::CTX_TERM;
                else if (k == 2)
                    r = 9'd6;
                else if (k == 3)
                    r = 9'd7;
                else if (k == 4)
                    r = bit_of(s, 3) ? 9'd8 : 9'd9;
                else if (k == 5)
                    r = bit_of(s, 3) ? 9'd9 : 9'd10;
                else
                    r = 9'd10;
            end
            cmhb_pkg::SCH_SUF:
            begin
                if (k == 0)
                    r = c0;
                else if (k == 1)
                    r = cmhb_pkg::CTX_TERM;
                else if (k == 2)
                    r = c0 + 9'd1;
                else if (k == 3)
                    r = c0 + 9'd2;
                else if (k == 4)
                    r = c0 + (bit_of(s, 3) ? 9'd2 : 9'd3);
                else
                    r = c0 + 9'd3;
            end
            cmhb_pkg::SCH_PPRE:
            begin
                if (k == 0)
                    r = 9'd14;
                else if (k == 1)
                    r = 9'd15;
                else
                    r = bit_of(s, 1) ? 9'd17 : 9'd16;
            end
            default:
            begin
                if (k == 0)
                    r = c0;
                else if (k == 1)
                    r = 9'd30;
                else if (k == 2)
                    r = bit_of(s, 1) ? 9'd31 : 9'd32;
                else
                    r = 9'd32;
            end
        endcase
        return r;
    endfunction

    function automatic logic type_cond(logic present, logic [2:0] kind, logic [8:0] offset);
        if (!present)
            return 1'b0;
        if (offset == cmhb_pkg::CTX_SI_PRE && kind == cmhb_pkg::KIND_SI)
            return 1'b0;
        if (offset == cmhb_pkg::CTX_I_BASE && kind == cmhb_pkg::KIND_I_NXN)
            return 1'b0;
        if (offset == cmhb_pkg::CTX_B_PRE
            && (kind == cmhb_pkg::KIND_B_SKIP || kind == cmhb_pkg::KIND_B_DIRECT))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [8:0] type_ctx(element_t e, logic [8:0] offset);
        return offset + 9'(type_cond(e.left_present, e.left_kind, offset))
                      + 9'(type_cond(e.above_present, e.above_kind, offset));
    endfunction

    function automatic logic chroma_cond(logic present, logic [2:0] kind, logic nz);
        if (!present)
            return 1'b0;
        if (kind == cmhb_pkg::KIND_INTER || kind == cmhb_pkg::KIND_B_SKIP
            || kind == cmhb_pkg::KIND_B_DIRECT || kind == cmhb_pkg::KIND_I_PCM)
            return 1'b0;
        return nz;
    endfunction

    task automatic add_bin(logic b, logic [8:0] ctx);
        bin_t r;
        r.bin_val = b;
        r.ctx     = ctx;
        r.term    = (ctx == cmhb_pkg::CTX_TERM);
        r.err     = 1'b0;
        r.last    = 1'b0;
        element_bins.push_back(r);
    endtask

    task automatic add_string(bin_string_t s, cmhb_pkg::sch_t sch, logic [8:0] c0);
        for (int k = 0; k < s.len; k++)
            add_bin(bit_of(s, k), pick_ctx(sch, k, s, c0));
    endtask

    // leaves element_bins empty when the type is not valid for the slice
    task automatic add_mb_type(element_t e);
        int unsigned raw;
        raw = e.value;
        case (slice_now)
            cmhb_pkg::SLICE_I:
                if (raw <= 25)
                    add_string(intra_string(raw), cmhb_pkg::SCH_I,
                               type_ctx(e, cmhb_pkg::CTX_I_BASE));
            cmhb_pkg::SLICE_SI:
                if (raw <= 26)
                begin
                    add_bin(raw != 0, type_ctx(e, cmhb_pkg::CTX_SI_PRE));
                    if (raw != 0)
                        add_string(intra_string(raw - 1), cmhb_pkg::SCH_I,
                                   type_ctx(e, cmhb_pkg::CTX_I_BASE));
                end
            cmhb_pkg::SLICE_P:
                if (raw < 4)
                    add_string({7'((4 - raw) % 4), 6'd3}, cmhb_pkg::SCH_PPRE,
                               cmhb_pkg::CTX_P_PRE);
                else if (raw != 4 && raw <= 30)
                begin
                    add_bin(1'b1, cmhb_pkg::CTX_P_PRE);
                    add_string(intra_string(raw - 5), cmhb_pkg::SCH_SUF, cmhb_pkg::CTX_P_SUF);
                end
            default:
                if (raw <= 22)
                    add_string(b_string(raw), cmhb_pkg::SCH_BPRE,
                               type_ctx(e, cmhb_pkg::CTX_B_PRE));
                else if (raw <= 48)
                begin
                    // intra escape prefix, then the intra string as a suffix
                    add_string({cmhb_pkg::B_INTRA_PREFIX, 6'd6}, cmhb_pkg::SCH_BPRE,
                               type_ctx(e, cmhb_pkg::CTX_B_PRE));
                    add_string(intra_string(raw - 23), cmhb_pkg::SCH_SUF,
                               cmhb_pkg::CTX_B_SUF);
                end
        endcase
    endtask

    task automatic binarize(element_t e);
        bin_t r;
        int   v;
        int   run;
        logic [8:0] c0;
        element_bins.delete();
        case (e.command)
            cmhb_pkg::CMD_MB_TYPE:
                add_mb_type(e);
            cmhb_pkg::CMD_MB_SKIP:
            begin
                c0 = (slice_now == cmhb_pkg::SLICE_P) ? cmhb_pkg::CTX_P_SKIP
                                                      : cmhb_pkg::CTX_B_SKIP;
                c0 = c0 + 9'(e.left_present && !e.left_skipped)
                        + 9'(e.above_present && !e.above_skipped);
                if (slice_now == cmhb_pkg::SLICE_P || slice_now == cmhb_pkg::SLICE_B)
                    add_bin(e.value[0], c0);
            end
            cmhb_pkg::CMD_CHROMA_MODE:
            begin
                c0 = cmhb_pkg::CTX_CHROMA
                    + 9'(chroma_cond(e.left_present, e.left_kind, e.left_chroma))
                    + 9'(chroma_cond(e.above_present, e.above_kind, e.above_chroma));
                if (e.value <= 3)
                    for (int k = 0; k < 3 && k <= e.value; k++)
                        add_bin(k < e.value, (k == 0) ? c0 : cmhb_pkg::CTX_CHROMA_R);
            end
            cmhb_pkg::CMD_QP_DELTA:
            begin
                v = $signed(e.qp_delta);
                if (v >= -26 && v <= 25)
                begin
                    run = (v <= 0) ? -2 * v : 2 * v - 1;
                    for (int k = 0; k <= run; k++)
                        add_bin(k < run, (k == 0) ? cmhb_pkg::CTX_QP_FIRST :
                                         (k == 1) ? cmhb_pkg::CTX_QP_SECOND
                                                  : cmhb_pkg::CTX_QP_REST);
                end
            end
            cmhb_pkg::CMD_END_OF_SLICE:
                add_bin(e.value[0], cmhb_pkg::CTX_TERM);
            default:
                ;
        endcase
        if (element_bins.size() == 0)
        begin
            r      = '0;
            r.err  = 1'b1;
            r.last = 1'b1;
            expected_bins.push_back(r);
        end
        else
        begin
            r = element_bins.pop_back();
            r.last = 1'b1;
            element_bins.push_back(r);
            foreach (element_bins[i])
                expected_bins.push_back(element_bins[i]);
        end
    endtask

    // mostly well-formed elements for the slice, some out of range or unknown
    function automatic element_t random_element(logic [1:0] slice);
        element_t e;
        int       pick;
        int       top;
        e.left_present  = 1'($urandom_range(1));
        e.left_skipped  = 1'($urandom_range(1));
        e.left_kind     = 3'($urandom_range(7));
        e.left_chroma   = 1'($urandom_range(1));
        e.above_present = 1'($urandom_range(1));
        e.above_skipped = 1'($urandom_range(1));
        e.above_kind    = 3'($urandom_range(7));
        e.above_chroma  = 1'($urandom_range(1));
        e.value         = 6'($urandom_range(63));
        e.qp_delta      = 6'($urandom_range(63));
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            e.command = cmhb_pkg::CMD_MB_TYPE;
            top = (slice == cmhb_pkg::SLICE_I) ? 25 : (slice == cmhb_pkg::SLICE_SI) ? 26 :
                  (slice == cmhb_pkg::SLICE_P) ? 30 : 48;
            if ($urandom_range(9) != 0)
                e.value = 6'($urandom_range(top));
        end
        else if (pick < 50)
            e.command = cmhb_pkg::CMD_MB_SKIP;
        else if (pick < 65)
        begin
            e.command = cmhb_pkg::CMD_CHROMA_MODE;
            if ($urandom_range(7) != 0)
                e.value = 6'($urandom_range(3));
        end
        else if (pick < 85)
        begin
            e.command = cmhb_pkg::CMD_QP_DELTA;
            pick = $urandom_range(9);
            // long unary runs are kept to a minority
            if (pick < 7)
                e.qp_delta = 6'(int'($urandom_range(8)) - 4);
            else if (pick < 9)
                e.qp_delta = 6'(int'($urandom_range(51)) - 26);
        end
        else if (pick < 95)
            e.command = cmhb_pkg::CMD_END_OF_SLICE;
        else
            e.command = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        return e;
    endfunction

    task automatic queue_item(logic [2:0] cmd, int value, int qp);
        element_t e;
        e          = random_element(slice_now);
        e.command  = cmd;
        e.value    = 6'(value);
        e.qp_delta = 6'(qp);
        pending_q.push_back(e);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_axis_tvalid || expected_bins.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_slice(logic [1:0] kind);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= kind;
        @(posedge clk);
        cfg_we    <= 1'b0;
        slice_now = kind;
        @(negedge clk);
    endtask

    // sender: offers queued elements, predicts the bins of each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                binarize(offered);
                accepted_items <= accepted_items + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    offered = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered.above_chroma, offered.above_kind,
                                      offered.above_skipped, offered.above_present,
                                      offered.left_chroma, offered.left_kind,
                                      offered.left_skipped, offered.left_present,
                                      offered.qp_delta, offered.value};
                    s_axis_tuser  <= offered.command;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off to back the block up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (!hold_done && accepted_items >= HOLD_AT)
        begin
            m_axis_tready <= 1'b0;
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin : check_bins
        bin_t got;
        bin_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tuser[0], m_axis_tuser[1],
                   m_axis_tlast};
            if (expected_bins.size() == 0)
            begin
                $display("%0t: unexpected transfer bin=%0d ctx=%0d term=%0d err=%0d last=%0d",
                         $time, got.bin_val, got.ctx, got.term, got.err, got.last);
                mismatches++;
            end
            else
            begin
                want = expected_bins.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected bin=%0d ctx=%0d term=%0d err=%0d last=%0d",
                             $time, want.bin_val, want.ctx, want.term, want.err, want.last);
                    $display("%0t:   actual bin=%0d ctx=%0d term=%0d err=%0d last=%0d",
                             $time, got.bin_val, got.ctx, got.term, got.err, got.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("cabac_mb_header_binarizer_core test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_slice(cmhb_pkg::SLICE_I);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 0, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 25, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 26, 0);
        queue_item(cmhb_pkg::CMD_MB_SKIP, 1, 0);
        queue_item(cmhb_pkg::CMD_END_OF_SLICE, 63, 0);
        queue_item(CMD_UNUSED_LO, 0, 0);
        queue_item(CMD_UNUSED_HI, 63, -1);

        set_slice(cmhb_pkg::SLICE_SI);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 0, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 26, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 27, 0);
        queue_item(cmhb_pkg::CMD_CHROMA_MODE, 3, 0);
        queue_item(cmhb_pkg::CMD_CHROMA_MODE, 4, 0);

        set_slice(cmhb_pkg::SLICE_P);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 3, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 4, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 5, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 30, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 31, 0);

        set_slice(cmhb_pkg::SLICE_B);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 22, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 23, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 48, 0);
        queue_item(cmhb_pkg::CMD_MB_TYPE, 49, 0);
        queue_item(cmhb_pkg::CMD_QP_DELTA, 0, -26);
        queue_item(cmhb_pkg::CMD_QP_DELTA, 63, 25);
        queue_item(cmhb_pkg::CMD_QP_DELTA, 0, 26);
        queue_item(cmhb_pkg::CMD_QP_DELTA, 0, -32);
        queue_item(cmhb_pkg::CMD_MB_SKIP, 0, 0);

        for (int p = 0; p < PHASES; p++)
        begin
            set_slice(2'(3 - p % 4));
            idle_pct = (p == 5) ? 0 : 37;
            repeat (PHASE_ITEMS) pending_q.push_back(random_element(slice_now));
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("cabac_mb_header_binarizer_core test passed");
        else
            $display("cabac_mb_header_binarizer_core test failed");
        $finish;
    end

endmodule
